// ----- hw/rtl/bqc_pkg.sv -----
`default_nettype none

package bqc_pkg;

	localparam int unsigned OUT_DEPTH_DEF = 8;

	typedef logic signed [63:0] acc_t;
	typedef logic signed [32:0] coef_t;

	typedef struct packed {
		logic vld;
		acc_t val;
	} smp_t;

	// feedback terms are held negated
	typedef struct packed {
		coef_t b_far;
		coef_t b_near;
		coef_t na_far;
		coef_t na_near;
	} sec_coef_t;

	typedef enum logic [2:0] {
		CFG_INPUT_SCALE = 3'd0,
		CFG_S0_A_FAR    = 3'd1,
		CFG_S0_A_NEAR   = 3'd2,
		CFG_S1_A_FAR    = 3'd3,
		CFG_S1_A_NEAR   = 3'd4,
		CFG_B_FAR       = 3'd5,
		CFG_B_NEAR      = 3'd6
	} cfg_idx_t;

	localparam logic [47:0] SCALE_RST      = 48'd95871898;
	localparam coef_t       S0_NA_FAR_RST  = -33'sd517080460;
	localparam coef_t       S0_NA_NEAR_RST = 33'sd1052681842;
	localparam coef_t       S1_NA_FAR_RST  = -33'sd490306279;
	localparam coef_t       S1_NA_NEAR_RST = 33'sd1025939911;
	localparam coef_t       B_FAR_RST      = 33'sd536870912;
	localparam coef_t       B_NEAR_RST     = 33'sd1073741824;

endpackage

`default_nettype wire

// ----- hw/rtl/cascaded_biquad_iir_filter_unit.sv -----
// Two-section direct-form-I biquad cascade, fixed point.
// s_axis: one Q1.23 sample per transfer in tdata[23:0].
// m_axis: tdata = Q8.24 filtered sample, tuser = 1 when it was clipped.
// cfg: index/data write channel, always ready; 0 input_scale, 1 s0_a_far,
//   2 s0_a_near, 3 s1_a_far, 4 s1_a_near, 5 b_far, 6 b_near; other
//   indexes are ignored. Write only while no sample is in flight.
// New samples enter while earlier ones are in flight, but never back to
//   back. The section feedback path (y[n-1] multiply, then join/clip/add)
//   spans two registers. Input transfer to m_axis_tvalid: input register,
//   two scaling stages, four stages per section, output buffer write.
// Results wait in an OUT_DEPTH entry buffer; s_axis_tready drops when
//   accepted-but-undelivered samples reach OUT_DEPTH, so a stalled
//   receiver loses nothing and the pipeline itself never stops.
// Reset clears all filter histories and loads the default coefficients.
`default_nettype none

module cascaded_biquad_iir_filter_unit #(
	parameter int unsigned OUT_DEPTH = bqc_pkg::OUT_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // [23:0] sample_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] sample_out
	output logic [0:0]       m_axis_tuser,   // [0] saturated
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);

	logic                 take, acc_q, room, sat;
	logic [47:0]          scale_q;
	bqc_pkg::coef_t       s0_na_far_q, s0_na_near_q, s1_na_far_q, s1_na_near_q;
	bqc_pkg::coef_t       b_far_q, b_near_q, cfg_c33;
	bqc_pkg::sec_coef_t   coef0, coef1;
	bqc_pkg::smp_t        x0, y0, y1;

	assign cfg_ready     = 1'b1;
	assign take          = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = room & ~acc_q;
	assign cfg_c33       = 33'(signed'(cfg_data[31:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= 1'b0;
			scale_q      <= bqc_pkg::SCALE_RST;
			s0_na_far_q  <= bqc_pkg::S0_NA_FAR_RST;
			s0_na_near_q <= bqc_pkg::S0_NA_NEAR_RST;
			s1_na_far_q  <= bqc_pkg::S1_NA_FAR_RST;
			s1_na_near_q <= bqc_pkg::S1_NA_NEAR_RST;
			b_far_q      <= bqc_pkg::B_FAR_RST;
			b_near_q     <= bqc_pkg::B_NEAR_RST;
		end else begin
			acc_q <= take;
			if (cfg_valid & cfg_ready) begin
				case (cfg_index)
					bqc_pkg::CFG_INPUT_SCALE: scale_q      <= cfg_data;
					bqc_pkg::CFG_S0_A_FAR:    s0_na_far_q  <= -cfg_c33;
					bqc_pkg::CFG_S0_A_NEAR:   s0_na_near_q <= -cfg_c33;
					bqc_pkg::CFG_S1_A_FAR:    s1_na_far_q  <= -cfg_c33;
					bqc_pkg::CFG_S1_A_NEAR:   s1_na_near_q <= -cfg_c33;
					bqc_pkg::CFG_B_FAR:       b_far_q      <= cfg_c33;
					bqc_pkg::CFG_B_NEAR:      b_near_q     <= cfg_c33;
					default: ;
				endcase
			end
		end
	end

	assign coef0 = '{b_far: b_far_q, b_near: b_near_q,
		na_far: s0_na_far_q, na_near: s0_na_near_q};
	assign coef1 = '{b_far: b_far_q, b_near: b_near_q,
		na_far: s1_na_far_q, na_near: s1_na_near_q};

	bqc_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.sample_in   (signed'(s_axis_tdata)),
		.input_scale (scale_q),
		.x_out       (x0)
	);

	bqc_section u_sec0 (
		.clk    (clk),
		.arst_n (arst_n),
		.x_in   (x0),
		.coef   (coef0),
		.y_out  (y0)
	);

	bqc_section u_sec1 (
		.clk    (clk),
		.arst_n (arst_n),
		.x_in   (y0),
		.coef   (coef1),
		.y_out  (y1)
	);

	bqc_obuf #(
		.DEPTH (OUT_DEPTH)
	) u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.y_in     (y1),
		.take     (take),
		.room     (room),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (sat)
	);

	assign m_axis_tuser = sat;

	a_pace: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !s_axis_tready)
		else $error("input transfers closer than two cycles");

endmodule

`default_nettype wire

// ----- hw/rtl/bqc_scale.sv -----
`default_nettype none

module bqc_scale (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic signed [23:0] sample_in,
	input  wire logic        [47:0] input_scale,
	output bqc_pkg::smp_t           x_out
);

	logic               v_s0, v_s1, v_s2;
	logic signed [23:0] smp_s0;
	logic signed [47:0] pph_s1, ppl_s1;
	bqc_pkg::acc_t      x0_s2;
	logic        [71:0] prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s0 <= take;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
		end
	end

	// exact sample * scale, floor-shifted by 23
	assign prod = {pph_s1, 24'd0} + {{24{ppl_s1[47]}}, ppl_s1};

	always_ff @(posedge clk) begin
		if (take) begin
			smp_s0 <= sample_in;
		end
		pph_s1 <= 48'(smp_s0) * 48'(signed'({1'b0, input_scale[47:24]}));
		ppl_s1 <= 48'(smp_s0) * 48'(signed'({1'b0, input_scale[23:0]}));
		x0_s2  <= {{15{prod[71]}}, prod[71:23]};
	end

	assign x_out.vld = v_s2;
	assign x_out.val = x0_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/bqc_section.sv -----
`default_nettype none

module bqc_section (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bqc_pkg::smp_t       x_in,
	input  wire bqc_pkg::sec_coef_t  coef,
	output bqc_pkg::smp_t            y_out
);

	localparam bqc_pkg::acc_t ACC_MAX = {1'b0, {63{1'b1}}};
	localparam bqc_pkg::acc_t ACC_MIN = {1'b1, {63{1'b0}}};

	function automatic bqc_pkg::acc_t sat_add(input bqc_pkg::acc_t a, input bqc_pkg::acc_t b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? ACC_MIN : ACC_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [64:0] mul_hi(input bqc_pkg::acc_t a,
			input bqc_pkg::coef_t c);
		return 65'(signed'(a[63:32])) * 65'(c);
	endfunction

	function automatic logic signed [65:0] mul_lo(input bqc_pkg::acc_t a,
			input bqc_pkg::coef_t c);
		return 66'(signed'({1'b0, a[31:0]})) * 66'(c);
	endfunction

	// join partial products, floor >> 29, clip to 64 bits
	function automatic bqc_pkg::acc_t q29_sat(input logic signed [64:0] ph,
			input logic signed [65:0] pl);
		logic [96:0] p;
		logic [67:0] r;
		p = {ph, 32'd0} + {{31{pl[65]}}, pl};
		r = p[96:29];
		if (r[67:63] != {5{r[63]}}) begin
			return r[67] ? ACC_MIN : ACC_MAX;
		end
		return r[63:0];
	endfunction

	logic                v_s1, v_s2, v_s3, v_s4;
	bqc_pkg::acc_t       xh1_q, xh2_q, yh1_q, yh2_q;
	bqc_pkg::acc_t       y2_sel, y_nxt;
	bqc_pkg::acc_t       x0_s1, a1_s2, pbn_s2, paf_s2, a3_s3;
	logic signed [64:0]  bf_h_s1, bn_h_s1, af_h_s1, an_h_s3;
	logic signed [65:0]  bf_l_s1, bn_l_s1, af_l_s1, an_l_s3;

	// previous item still in flight: its output is not in the history yet
	assign y2_sel = (v_s2 | v_s3) ? yh1_q : yh2_q;
	assign y_nxt  = sat_add(a3_s3, q29_sat(an_h_s3, an_l_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			xh1_q <= '0;
			xh2_q <= '0;
			yh1_q <= '0;
			yh2_q <= '0;
		end else begin
			v_s1 <= x_in.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (x_in.vld) begin
				xh1_q <= x_in.val;
				xh2_q <= xh1_q;
			end
			if (v_s3) begin
				yh1_q <= y_nxt;
				yh2_q <= yh1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		x0_s1   <= x_in.val;
		bf_h_s1 <= mul_hi(xh2_q, coef.b_far);
		bf_l_s1 <= mul_lo(xh2_q, coef.b_far);
		bn_h_s1 <= mul_hi(xh1_q, coef.b_near);
		bn_l_s1 <= mul_lo(xh1_q, coef.b_near);
		af_h_s1 <= mul_hi(y2_sel, coef.na_far);
		af_l_s1 <= mul_lo(y2_sel, coef.na_far);

		a1_s2  <= sat_add(x0_s1, q29_sat(bf_h_s1, bf_l_s1));
		pbn_s2 <= q29_sat(bn_h_s1, bn_l_s1);
		paf_s2 <= q29_sat(af_h_s1, af_l_s1);

		a3_s3   <= sat_add(sat_add(a1_s2, paf_s2), pbn_s2);
		an_h_s3 <= mul_hi(yh1_q, coef.na_near);
		an_l_s3 <= mul_lo(yh1_q, coef.na_near);
	end

	assign y_out.vld = v_s4;
	assign y_out.val = yh1_q;

	// the recursion cannot take items back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		x_in.vld |=> !x_in.vld)
		else $error("section input items closer than two cycles");

endmodule

`default_nettype wire

// ----- hw/rtl/bqc_obuf.sv -----
`default_nettype none

module bqc_obuf #(
	parameter int unsigned DEPTH = bqc_pkg::OUT_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bqc_pkg::smp_t y_in,
	input  wire logic          take,
	output logic               room,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [31:0]        m_tdata,
	output logic               m_tuser
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [32:0]   mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] fill_q, cred_q;
	logic          push, pop;
	logic [39:0]   o40;
	logic [32:0]   word;

	assign push = y_in.vld;
	assign pop  = m_tvalid & m_tready;

	// Q16.48 -> Q8.24 with clipping, flag in the top bit
	assign o40 = y_in.val[63:24];
	always_comb begin
		if (o40[39:31] == {9{o40[31]}}) begin
			word = {1'b0, o40[31:0]};
		end else if (o40[39]) begin
			word = {1'b1, 1'b1, 31'd0};
		end else begin
			word = {1'b1, 1'b0, {31{1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
			cred_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push & ~pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (~push & pop) begin
				fill_q <= fill_q - 1'b1;
			end
			if (take & ~pop) begin
				cred_q <= cred_q + 1'b1;
			end else if (~take & pop) begin
				cred_q <= cred_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= word;
		end
	end

	assign room     = cred_q < CW'(DEPTH);
	assign m_tvalid = fill_q != '0;
	assign m_tdata  = mem_q[rd_q][31:0];
	assign m_tuser  = mem_q[rd_q][32];

	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fill_q < CW'(DEPTH)))
		else $error("output buffer written while full");

	a_cred: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cred_q)
		else $error("buffered results exceed outstanding credit");

endmodule

`default_nettype wire

// ----- bench/biquad_cascade_checker.sv -----
module biquad_cascade_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	input  logic        s_ready,
	input  logic [23:0] s_data,    // [23:0] sample_in
	input  logic        m_valid,
	input  logic        m_ready,
	input  logic [31:0] m_data,    // [31:0] sample_out
	input  logic [0:0]  m_user,    // [0] saturated
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output int          errors,
	output int          backlog
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam bqc_pkg::acc_t ACC_MAX = {1'b0, {63{1'b1}}};
	localparam bqc_pkg::acc_t ACC_MIN = {1'b1, {63{1'b0}}};

	typedef struct packed {
		logic [31:0] sample;
		logic        clipped;
	} filt_out_t;

	filt_out_t filtered_q[$];
	filt_out_t want;

	logic [47:0]    in_scale;
	bqc_pkg::coef_t b_far_c;
	bqc_pkg::coef_t b_near_c;
	bqc_pkg::coef_t na_far[2];
	bqc_pkg::coef_t na_near[2];
	bqc_pkg::acc_t  x_hist[2];
	bqc_pkg::acc_t  y0_hist[2];
	bqc_pkg::acc_t  y1_hist[2];

	initial errors = 0;

	function automatic bqc_pkg::coef_t coef_of(logic [47:0] d);
		bqc_pkg::coef_t c;
		c = 33'($signed(d[31:0]));
		return c;
	endfunction

	// floor(v * c / 2^29), clipped to 64 bits
	function automatic bqc_pkg::acc_t mul_q29(bqc_pkg::acc_t v, bqc_pkg::coef_t c);
		logic signed [127:0] wv;
		logic signed [127:0] wc;
		logic signed [127:0] p;
		wv = 128'(v);
		wc = 128'(c);
		p = (wv * wc) >>> 29;
		if (p[127:63] != {65{p[127]}})
			return p[127] ? ACC_MIN : ACC_MAX;
		return p[63:0];
	endfunction

	function automatic bqc_pkg::acc_t add_sat(bqc_pkg::acc_t a, bqc_pkg::acc_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63])
			return s[64] ? ACC_MIN : ACC_MAX;
		return s[63:0];
	endfunction

	// feedback coefficients arrive already negated
	function automatic bqc_pkg::acc_t section(bqc_pkg::acc_t x0, bqc_pkg::acc_t x1,
			bqc_pkg::acc_t x2, bqc_pkg::acc_t y1, bqc_pkg::acc_t y2,
			bqc_pkg::coef_t naf, bqc_pkg::coef_t nan);
		bqc_pkg::acc_t acc;
		acc = x0;
		acc = add_sat(acc, mul_q29(x2, b_far_c));
		acc = add_sat(acc, mul_q29(y2, naf));
		acc = add_sat(acc, mul_q29(x1, b_near_c));
		acc = add_sat(acc, mul_q29(y1, nan));
		return acc;
	endfunction

	function automatic filt_out_t filter_sample(logic [23:0] raw);
		logic signed [127:0] wide;
		bqc_pkg::acc_t       x0;
		bqc_pkg::acc_t       y0;
		bqc_pkg::acc_t       y1;
		bqc_pkg::acc_t       o;
		filt_out_t           r;
		wide = 128'($signed(raw));
		wide = (wide * $signed({80'd0, in_scale})) >>> 23;
		x0 = wide[63:0];
		y0 = section(x0, x_hist[0], x_hist[1], y0_hist[0], y0_hist[1], na_far[0], na_near[0]);
		y1 = section(y0, y0_hist[0], y0_hist[1], y1_hist[0], y1_hist[1], na_far[1], na_near[1]);
		x_hist[1] = x_hist[0];
		x_hist[0] = x0;
		y0_hist[1] = y0_hist[0];
		y0_hist[0] = y0;
		y1_hist[1] = y1_hist[0];
		y1_hist[0] = y1;
		o = y1 >>> 24;
		r.clipped = (o[63:31] != {33{o[63]}});
		r.sample = r.clipped ? (o[63] ? 32'h8000_0000 : 32'h7fff_ffff) : o[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_scale = bqc_pkg::SCALE_RST;
			na_far[0] = bqc_pkg::S0_NA_FAR_RST;
			na_near[0] = bqc_pkg::S0_NA_NEAR_RST;
			na_far[1] = bqc_pkg::S1_NA_FAR_RST;
			na_near[1] = bqc_pkg::S1_NA_NEAR_RST;
			b_far_c = bqc_pkg::B_FAR_RST;
			b_near_c = bqc_pkg::B_NEAR_RST;
			x_hist = '{default: '0};
			y0_hist = '{default: '0};
			y1_hist = '{default: '0};
			filtered_q.delete();
			backlog <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (bqc_pkg::cfg_idx_t'(cfg_index))
					bqc_pkg::CFG_INPUT_SCALE: in_scale = cfg_data;
					bqc_pkg::CFG_S0_A_FAR:    na_far[0] = -coef_of(cfg_data);
					bqc_pkg::CFG_S0_A_NEAR:   na_near[0] = -coef_of(cfg_data);
					bqc_pkg::CFG_S1_A_FAR:    na_far[1] = -coef_of(cfg_data);
					bqc_pkg::CFG_S1_A_NEAR:   na_near[1] = -coef_of(cfg_data);
					bqc_pkg::CFG_B_FAR:       b_far_c = coef_of(cfg_data);
					bqc_pkg::CFG_B_NEAR:      b_near_c = coef_of(cfg_data);
					default: ;
				endcase
			end
			if (s_valid && s_ready)
				filtered_q.push_back(filter_sample(s_data));
			if (m_valid && m_ready) begin
				if (filtered_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, actual sample_out %h saturated %b",
						$time, m_data, m_user[0]);
				end else begin
					want = filtered_q.pop_front();
					if (want.sample !== m_data) begin
						errors++;
						$display("%0t: sample_out mismatch: expected %h, actual %h",
							$time, want.sample, m_data);
					end
					if (want.clipped !== m_user[0]) begin
						errors++;
						$display("%0t: saturated mismatch: expected %b, actual %b",
							$time, want.clipped, m_user[0]);
					end
				end
			end
			backlog <= filtered_q.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0]  CFG_UNUSED  = 3'd7;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned LIMIT       = 150000;
	localparam int unsigned RAND_ITEMS  = 750;
	localparam int unsigned PHASES      = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_valid = 1'b0;
	logic        s_ready;
	logic [23:0] s_data = '0;
	logic        m_valid;
	logic        m_ready = 1'b0;
	logic [31:0] m_data;
	logic [0:0]  m_user;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;

	int          errors;
	int          backlog;
	int unsigned cycles = 0;
	bit          jitter = 1'b1;
	bit          hold_req = 1'b0;

	cascaded_biquad_iir_filter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	biquad_cascade_checker i_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_valid),
		.s_ready   (s_ready),
		.s_data    (s_data),
		.m_valid   (m_valid),
		.m_ready   (m_ready),
		.m_data    (m_data),
		.m_user    (m_user),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.backlog   (backlog)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				m_ready <= 1'b1;
			end else if (jitter && $urandom_range(0, 4) == 0) begin
				m_ready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(posedge clk);
			end else begin
				m_ready <= 1'b1;
			end
		end
	end

	task automatic send(input logic [23:0] v);
		if (jitter && $urandom_range(0, 3) == 0) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= v;
		do @(posedge clk); while (!s_ready);
	endtask

	task automatic drain();
		s_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [47:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_all(input logic [47:0] scale, input logic [47:0] s0f,
			input logic [47:0] s0n, input logic [47:0] s1f, input logic [47:0] s1n,
			input logic [47:0] bf, input logic [47:0] bn);
		cfg_write(bqc_pkg::CFG_INPUT_SCALE, scale);
		cfg_write(bqc_pkg::CFG_S0_A_FAR, s0f);
		cfg_write(bqc_pkg::CFG_S0_A_NEAR, s0n);
		cfg_write(bqc_pkg::CFG_S1_A_FAR, s1f);
		cfg_write(bqc_pkg::CFG_S1_A_NEAR, s1n);
		cfg_write(bqc_pkg::CFG_B_FAR, bf);
		cfg_write(bqc_pkg::CFG_B_NEAR, bn);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_defaults(input logic [47:0] scale);
		program_all(scale, 48'(-bqc_pkg::S0_NA_FAR_RST), 48'(-bqc_pkg::S0_NA_NEAR_RST),
			48'(-bqc_pkg::S1_NA_FAR_RST), 48'(-bqc_pkg::S1_NA_NEAR_RST),
			48'(bqc_pkg::B_FAR_RST), 48'(bqc_pkg::B_NEAR_RST));
	endtask

	// zero scale and coefficients flush both histories in two samples
	task automatic clear_history();
		program_all('0, '0, '0, '0, '0, '0, '0);
		send(24'($urandom));
		send(24'($urandom));
		drain();
	endtask

	function automatic logic [23:0] rand_sample();
		logic [23:0] v;
		v = 24'($urandom);
		case ($urandom_range(0, 9))
			0: v = 24'h7f_ffff;
			1: v = 24'h80_0000;
			2: v = {{16{v[7]}}, v[7:0]};
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [47:0] rand_coef();
		logic [47:0] d;
		d[47:32] = 16'($urandom);
		d[31:0] = $urandom;
		case ($urandom_range(0, 6))
			0: d[31:0] = 32'h8000_0000;
			1: d[31:0] = 32'h7fff_ffff;
			2: d[31:0] = '0;
			3, 4: d[31:0] = {{4{d[27]}}, d[27:0]};
			default: ;
		endcase
		return d;
	endfunction

	function automatic logic [47:0] rand_scale();
		logic [47:0] d;
		d[47:32] = 16'($urandom);
		d[31:0] = $urandom;
		case ($urandom_range(0, 4))
			0: d = '0;
			1: d = '1;
			2: d = bqc_pkg::SCALE_RST;
			3: d = d >> $urandom_range(0, 40);
			default: ;
		endcase
		return d;
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: zero, full scale, unit steps
		send(24'h00_0000);
		send(24'h7f_ffff);
		send(24'h80_0000);
		send(24'h00_0001);
		send(24'hff_ffff);
		repeat (4) send(24'h7f_ffff);
		repeat (3) send(24'h80_0000);
		repeat (3) send(24'h00_0000);
		drain();

		// unstable extremes: internal products and sums clip, output clips
		cfg_write(CFG_UNUSED, 48'({$urandom, $urandom}));
		program_all('1, 48'h7fff_ffff, 48'h8000_0000, 48'h8000_0000, 48'h8000_0000,
			48'h7fff_ffff, 48'h8000_0000);
		repeat (3) send(24'h7f_ffff);
		repeat (3) send(24'h80_0000);
		send(24'h00_0000);
		send(24'h00_0000);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1)
				jitter = 1'b0;
			case (ph % 3)
				0: begin
					clear_history();
					program_defaults(bqc_pkg::SCALE_RST);
				end
				1: program_defaults(rand_scale());
				default: program_all(rand_scale(), rand_coef(), rand_coef(), rand_coef(),
					rand_coef(), rand_coef(), rand_coef());
			endcase
			if (ph == 1)
				hold_req = 1'b1;
			repeat (RAND_ITEMS / PHASES) send(rand_sample());
			drain();
		end

		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
